// File: src/prle_pkg.sv
// Package for the planar RLE image decoder: phase type, error codes, widths.
// No dependencies.
package prle_pkg;

  localparam int HEADER_BYTES_DEF = 2;
  localparam int PLANE_COUNT_DEF  = 4;

  localparam int SPAN_W  = 16;
  localparam int FILL_W  = 17;
  localparam int COUNT_W = 7;
  localparam int PLANE_W = 2;
  localparam int BYTE_W  = 8;
  localparam int ERR_W   = 3;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_PACKET  = 3'd1,
    PH_LITERAL = 3'd2,
    PH_RUNVAL  = 3'd3,
    PH_DONE    = 3'd4,
    PH_ERROR   = 3'd5
  } phase_t;

  typedef logic [ERR_W-1:0] err_t;

  localparam err_t ERR_NONE      = 3'd0;
  localparam err_t ERR_SHORT_HDR = 3'd1;
  localparam err_t ERR_ZERO_SPAN = 3'd2;
  localparam err_t ERR_TRUNC_PKT = 3'd3;
  localparam err_t ERR_TRUNC_LIT = 3'd4;
  localparam err_t ERR_TRUNC_RUN = 3'd5;
  localparam err_t ERR_OVERRUN   = 3'd6;
  localparam err_t ERR_TRAILING  = 3'd7;

endpackage

// File: src/planar_rle_image_decoder.sv
// Planar RLE image decoder, top level: header parse, packet decode, result register.
// Depends on prle_pkg.
//
// Usage:
//   Input channel (in_valid/in_stall): one encoded byte per word, in_last_byte
//   marking the final byte of an image. The stream opens with HEADER_BYTES
//   header bytes (first two give the plane length, little endian), then
//   packets fill PLANE_COUNT planes in turn.
//   Result channel (out_valid/out_stall): at most one word per input byte,
//   carrying plane, value, repeat count and image_done, or a status word
//   (repeat 0) with image_done or an error code; bytes that cause nothing give none.
//   cfg_wr_en/cfg_wr_data write strict_end; write only while idle.
// Output and throughput:
//   A result is registered in out_* in the cycle after its byte is taken. One
//   byte per cycle while out_stall holds no result; the byte is decoded by
//   single-level logic from the phase and counters straight into the result register.
// Stall:
//   in_stall is high only while a result is held and out_stall is high; the
//   block takes a new byte in the same cycle the held result leaves.
// Reset:
//   rst_n low clears out_valid, returns to header phase and sets
//   strict_end to 1. No clearing pass.
module planar_rle_image_decoder
  import prle_pkg::*;
#(
  parameter int HEADER_BYTES = HEADER_BYTES_DEF,
  parameter int PLANE_COUNT  = PLANE_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [BYTE_W-1:0]  in_byte,
  input  logic               in_last_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [PLANE_W-1:0] out_plane,
  output logic [BYTE_W-1:0]  out_value,
  output logic [COUNT_W-1:0] out_repeat_res,
  output logic               out_image_done,
  output logic [ERR_W-1:0]   out_error
);

  localparam int HC_W = $clog2(HEADER_BYTES);

  phase_t              phase_r, phase_nxt;
  logic [HC_W-1:0]     hc_r, hc_nxt;
  logic [SPAN_W-1:0]   span_r, span_nxt;
  logic [PLANE_W-1:0]  pidx_r, pidx_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic [COUNT_W-1:0]  left_r, left_nxt;
  logic                strict_r;

  logic                out_valid_r;
  logic [PLANE_W-1:0]  out_plane_r;
  logic [BYTE_W-1:0]   out_value_r;
  logic [COUNT_W-1:0]  out_rep_r;
  logic                out_done_r;
  err_t                out_err_r;

  logic                res_vld;
  logic [PLANE_W-1:0]  res_plane;
  logic [BYTE_W-1:0]   res_value;
  logic [COUNT_W-1:0]  res_rep;
  logic                res_done;
  err_t                res_err;

  logic                accept;
  logic [SPAN_W-1:0]   hdr_span;
  logic                hdr_last;
  logic [COUNT_W-1:0]  left_dec;
  logic [FILL_W-1:0]   fill_lit;
  logic [FILL_W:0]     run_sum;
  logic                run_over;
  logic                lit_data;
  logic                lit_end;
  logic                lit_over;
  logic [FILL_W-1:0]   fill_after;
  logic                plane_full;
  logic                last_plane;
  logic [PLANE_W-1:0]  pidx_inc;
  logic                cmp_go;
  logic                cmp_data;
  logic [COUNT_W-1:0]  cmp_rep;
  logic                cmp_done;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign hdr_span = (hc_r == '0) ? {{(SPAN_W-BYTE_W){1'b0}}, in_byte} :
                    (hc_r == HC_W'(1)) ? {in_byte, span_r[BYTE_W-1:0]} : span_r;
  assign hdr_last = (hc_r == HC_W'(HEADER_BYTES - 1));

  assign left_dec   = left_r - COUNT_W'(1);
  assign fill_lit   = fill_r + FILL_W'(1);
  assign run_sum    = {1'b0, fill_r} + (FILL_W+1)'(left_r);
  assign run_over   = run_sum > (FILL_W+1)'(span_r);
  assign lit_data   = fill_r < FILL_W'(span_r);
  assign lit_end    = (left_dec == '0);
  assign lit_over   = fill_lit > FILL_W'(span_r);
  assign fill_after = (phase_r == PH_LITERAL) ? fill_lit :
                      (phase_r == PH_RUNVAL) ? run_sum[FILL_W-1:0] : fill_r;
  assign plane_full = (fill_after == FILL_W'(span_r));
  assign last_plane = (pidx_r >= PLANE_W'(PLANE_COUNT - 1));
  assign pidx_inc   = pidx_r + PLANE_W'(1);

  // packet completion: empty literal, last literal byte in range, run value in range
  assign cmp_go   = ((phase_r == PH_PACKET) && (in_byte == '0)) ||
                    ((phase_r == PH_LITERAL) && lit_end && !lit_over) ||
                    ((phase_r == PH_RUNVAL) && !run_over);
  assign cmp_data = (phase_r == PH_LITERAL) ? lit_data :
                    (phase_r == PH_RUNVAL) ? (left_r != '0) : 1'b0;
  assign cmp_rep  = (phase_r == PH_LITERAL) ? COUNT_W'(1) : left_r;
  assign cmp_done = !strict_r || in_last_byte;

  // next state; every marked last byte returns to header phase
  always_comb begin
    phase_nxt = phase_r;
    hc_nxt    = hc_r;
    span_nxt  = span_r;
    pidx_nxt  = pidx_r;
    fill_nxt  = fill_r;
    left_nxt  = left_r;
    if (in_last_byte) begin
      phase_nxt = PH_HEADER;
      hc_nxt    = '0;
      span_nxt  = '0;
      pidx_nxt  = '0;
      fill_nxt  = '0;
      left_nxt  = '0;
    end else if (cmp_go) begin
      left_nxt = (phase_r == PH_LITERAL) ? left_dec :
                 (phase_r == PH_RUNVAL) ? '0 : left_r;
      if (plane_full) begin
        fill_nxt = '0;
        if (last_plane) begin
          phase_nxt = PH_DONE;
        end else begin
          pidx_nxt  = pidx_inc;
          phase_nxt = PH_PACKET;
        end
      end else begin
        fill_nxt  = fill_after;
        phase_nxt = PH_PACKET;
      end
    end else begin
      unique case (phase_r)
        PH_HEADER: begin
          span_nxt = hdr_span;
          if (hdr_last) begin
            if (hdr_span == '0) begin
              phase_nxt = PH_ERROR;
            end else begin
              phase_nxt = PH_PACKET;
              pidx_nxt  = '0;
              fill_nxt  = '0;
              left_nxt  = '0;
            end
          end else begin
            hc_nxt = hc_r + HC_W'(1);
          end
        end
        PH_PACKET: begin
          left_nxt  = in_byte[COUNT_W-1:0];
          phase_nxt = in_byte[BYTE_W-1] ? PH_RUNVAL : PH_LITERAL;
        end
        PH_LITERAL: begin
          fill_nxt = fill_lit;
          left_nxt = left_dec;
          if (lit_end) begin
            phase_nxt = PH_ERROR;
          end
        end
        PH_RUNVAL: begin
          phase_nxt = PH_ERROR;
        end
        PH_DONE: begin
          if (strict_r) begin
            phase_nxt = PH_ERROR;
          end
        end
        default: begin
          phase_nxt = PH_ERROR;
        end
      endcase
    end
  end

  // result word
  always_comb begin
    res_vld   = 1'b0;
    res_plane = pidx_r;
    res_value = '0;
    res_rep   = '0;
    res_done  = 1'b0;
    res_err   = ERR_NONE;
    if (cmp_go) begin
      if (plane_full && last_plane) begin
        res_vld   = cmp_data || cmp_done;
        res_value = cmp_data ? in_byte : '0;
        res_rep   = cmp_data ? cmp_rep : '0;
        res_done  = cmp_done;
      end else if (in_last_byte) begin
        res_vld   = 1'b1;
        res_err   = ERR_TRUNC_PKT;
        res_plane = plane_full ? pidx_inc : pidx_r;
      end else if (cmp_data) begin
        res_vld   = 1'b1;
        res_value = in_byte;
        res_rep   = cmp_rep;
      end
    end else begin
      unique case (phase_r)
        PH_HEADER: begin
          if (hdr_last && (hdr_span == '0)) begin
            res_vld = 1'b1;
            res_err = ERR_ZERO_SPAN;
          end else if (in_last_byte) begin
            res_vld = 1'b1;
            res_err = hdr_last ? ERR_TRUNC_PKT : ERR_SHORT_HDR;
          end
        end
        PH_PACKET: begin
          if (in_last_byte) begin
            res_vld = 1'b1;
            res_err = in_byte[BYTE_W-1] ? ERR_TRUNC_RUN : ERR_TRUNC_LIT;
          end
        end
        PH_LITERAL: begin
          if (lit_end) begin
            res_vld = 1'b1;
            res_err = ERR_OVERRUN;
          end else if (in_last_byte) begin
            res_vld = 1'b1;
            res_err = ERR_TRUNC_LIT;
          end else if (lit_data) begin
            res_vld   = 1'b1;
            res_value = in_byte;
            res_rep   = COUNT_W'(1);
          end
        end
        PH_RUNVAL: begin
          res_vld = 1'b1;
          res_err = ERR_OVERRUN;
        end
        PH_DONE: begin
          if (strict_r) begin
            res_vld = 1'b1;
            res_err = ERR_TRAILING;
          end
        end
        default: begin
          res_vld = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      hc_r     <= '0;
      span_r   <= '0;
      pidx_r   <= '0;
      fill_r   <= '0;
      left_r   <= '0;
      strict_r <= 1'b1;
    end else begin
      if (cfg_wr_en) begin
        strict_r <= cfg_wr_data;
      end
      if (accept) begin
        phase_r <= phase_nxt;
        hc_r    <= hc_nxt;
        span_r  <= span_nxt;
        pidx_r  <= pidx_nxt;
        fill_r  <= fill_nxt;
        left_r  <= left_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && res_vld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_vld) begin
      out_plane_r <= res_plane;
      out_value_r <= res_value;
      out_rep_r   <= res_rep;
      out_done_r  <= res_done;
      out_err_r   <= res_err;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_plane      = out_plane_r;
  assign out_value      = out_value_r;
  assign out_repeat_res = out_rep_r;
  assign out_image_done = out_done_r;
  assign out_error      = out_err_r;

`ifndef SYNTH
  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last_byte) |=> (phase_r == PH_HEADER && fill_r == '0 && hc_r == '0))
    else $error("marked last byte did not return to header phase");

  a_literal_left: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_LITERAL) |-> (left_r != '0))
    else $error("literal phase with no bytes left");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PACKET || phase_r == PH_RUNVAL) |->
      (fill_r <= FILL_W'(span_r) && pidx_r <= PLANE_W'(PLANE_COUNT - 1)))
    else $error("plane fill or index out of range between packets");

  a_status_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error != ERR_NONE) |-> (out_repeat_res == '0 && !out_image_done))
    else $error("error word carries data or done");
`endif

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for planar_rle_image_decoder: directed and random encoded images,
// with a scoreboard class that predicts every result word. Depends on prle_pkg and the RTL.
import prle_pkg::*;

typedef struct packed {
  logic [PLANE_W-1:0] plane;
  logic [BYTE_W-1:0]  value;
  logic [COUNT_W-1:0] rep_cnt;
  logic               done;
  err_t               error;
} prle_word_t;

class prle_scoreboard;
  bit                 strict_end;
  phase_t             phase;
  logic [3:0]         hdr_count;
  logic [SPAN_W-1:0]  span;
  logic [PLANE_W-1:0] plane_idx;
  logic [FILL_W-1:0]  fill;
  logic [COUNT_W-1:0] left;
  prle_word_t         due_q[$];
  int                 fails;

  function new();
    strict_end = 1'b1;
    fails = 0;
    restart();
  endfunction

  function void restart();
    phase = PH_HEADER;
    hdr_count = '0;
    span = '0;
    plane_idx = '0;
    fill = '0;
    left = '0;
  endfunction

  function void push(logic [PLANE_W-1:0] pl, logic [BYTE_W-1:0] val,
                     logic [COUNT_W-1:0] rep, logic done, err_t code);
    prle_word_t w;
    w = '{plane: pl, value: val, rep_cnt: rep, done: done, error: code};
    due_q.push_back(w);
  endfunction

  // status word; the stream is dropped until a marked last byte
  function void flag(bit last, err_t code);
    logic [PLANE_W-1:0] pl;
    pl = plane_idx;
    if (last) restart();
    else phase = PH_ERROR;
    push(pl, '0, '0, 1'b0, code);
  endfunction

  function void close_packet(bit last, bit data, logic [PLANE_W-1:0] pl,
                             logic [BYTE_W-1:0] val, logic [COUNT_W-1:0] rep);
    bit done;
    if (int'(fill) == int'(span)) begin
      fill = '0;
      if (plane_idx >= PLANE_COUNT_DEF - 1) begin
        done = !strict_end || last;
        phase = PH_DONE;
        if (last) restart();
        if (data || done) push(pl, data ? val : '0, data ? rep : '0, done, ERR_NONE);
        return;
      end
      plane_idx = plane_idx + 1'b1;
    end
    phase = PH_PACKET;
    if (last) flag(1'b1, ERR_TRUNC_PKT);
    else if (data) push(pl, val, rep, 1'b0, ERR_NONE);
  endfunction

  function void note_byte(logic [BYTE_W-1:0] b, bit last);
    logic [PLANE_W-1:0] pl;
    logic [COUNT_W-1:0] cnt;
    bit data;
    pl = plane_idx;
    case (phase)
      PH_HEADER: begin
        if (hdr_count == 0) span = {8'd0, b};
        else if (hdr_count == 1) span = {b, span[7:0]};
        if (hdr_count >= HEADER_BYTES_DEF - 1) begin
          if (span == 0) begin
            flag(last, ERR_ZERO_SPAN);
          end else begin
            phase = PH_PACKET;
            plane_idx = '0;
            fill = '0;
            left = '0;
            if (last) flag(1'b1, ERR_TRUNC_PKT);
          end
        end else begin
          hdr_count = hdr_count + 1'b1;
          if (last) flag(1'b1, ERR_SHORT_HDR);
        end
      end
      PH_PACKET: begin
        if (b[7]) begin
          left = b[6:0];
          phase = PH_RUNVAL;
          if (last) flag(1'b1, ERR_TRUNC_RUN);
        end else if (b != 0) begin
          left = b[6:0];
          phase = PH_LITERAL;
          if (last) flag(1'b1, ERR_TRUNC_LIT);
        end else begin
          close_packet(last, 1'b0, '0, '0, '0);
        end
      end
      PH_LITERAL: begin
        data = fill < {1'b0, span};
        fill = fill + 1'b1;
        left = left - 1'b1;
        if (left != 0) begin
          if (last) flag(1'b1, ERR_TRUNC_LIT);
          else if (data) push(pl, b, 7'd1, 1'b0, ERR_NONE);
        end else if (fill > {1'b0, span}) begin
          flag(last, ERR_OVERRUN);
        end else begin
          close_packet(last, data, pl, b, 7'd1);
        end
      end
      PH_RUNVAL: begin
        cnt = left;
        if (int'(fill) + int'(cnt) > int'(span)) begin
          flag(last, ERR_OVERRUN);
        end else begin
          fill = fill + cnt;
          left = '0;
          close_packet(last, cnt != 0, pl, b, cnt);
        end
      end
      PH_DONE: begin
        if (strict_end) flag(last, ERR_TRAILING);
        else if (last) restart();
      end
      default: begin
        if (last) restart();
      end
    endcase
  endfunction

  function void cmp(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
      fails++;
    end
  endfunction

  function void check_word(logic [PLANE_W-1:0] pl, logic [BYTE_W-1:0] val,
                           logic [COUNT_W-1:0] rep, logic done, err_t code);
    prle_word_t w;
    if (due_q.size() == 0) begin
      $display({"%0t: word with nothing due, expected none actual ",
                "plane %0d value %0d rep %0d done %0d err %0d"},
               $time, pl, val, rep, done, code);
      fails++;
      return;
    end
    w = due_q.pop_front();
    cmp("plane", w.plane, pl);
    cmp("value", w.value, val);
    cmp("repeat", w.rep_cnt, rep);
    cmp("image_done", w.done, done);
    cmp("error", w.error, code);
  endfunction
endclass

module tb;
  typedef struct {
    logic [BYTE_W-1:0] data;
    bit                last;
  } stream_word_t;

  // bit 8 marks the last byte of an image
  localparam logic [8:0] DIRECTED [27] = '{
    9'h105,
    9'h000, 9'h100,
    9'h0FF, 9'h1FF,
    9'h001, 9'h000, 9'h002, 9'h111,
    9'h002, 9'h000, 9'h185,
    9'h001, 9'h000, 9'h085, 9'h177,
    9'h001, 9'h000, 9'h001, 9'h0FF, 9'h081, 9'h000, 9'h081, 9'h020, 9'h001, 9'h07F,
    9'h1EE
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic               cfg_wr_data = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [BYTE_W-1:0]  in_byte = '0;
  logic               in_last_byte = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [PLANE_W-1:0] out_plane;
  logic [BYTE_W-1:0]  out_value;
  logic [COUNT_W-1:0] out_repeat_res;
  logic               out_image_done;
  logic [ERR_W-1:0]   out_error;

  bit in_idle = 1'b1;
  bit out_idle = 1'b1;
  bit long_hold_req = 1'b0;

  stream_word_t   stream_q[$];
  prle_scoreboard sb = new();

  always #2 clk = ~clk;

  planar_rle_image_decoder u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_plane      (out_plane),
    .out_value      (out_value),
    .out_repeat_res (out_repeat_res),
    .out_image_done (out_image_done),
    .out_error      (out_error)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_word(out_plane, out_value, out_repeat_res, out_image_done, out_error);
      if (in_valid && !in_stall) sb.note_byte(in_byte, in_last_byte);
    end
  end

  function automatic void put(logic [BYTE_W-1:0] d, bit l = 1'b0);
    stream_word_t w;
    w.data = d;
    w.last = l;
    stream_q.push_back(w);
  endfunction

  function automatic void add_image();
    int unsigned span, fill, lim, n, first, kind, lit_max, cut;
    bit wild;
    first = stream_q.size();
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      repeat ($urandom_range(1, 10))
        put(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      stream_q[stream_q.size() - 1].last = 1'b1;
      return;
    end
    case ($urandom_range(0, 9))
      7, 8:    span = $urandom_range(25, 255);
      9:       span = $urandom_range(256, 700);
      default: span = $urandom_range(1, 24);
    endcase
    lit_max = (span > 24) ? 6 : 127;
    wild = (kind == 6);
    put(span[7:0]);
    put(span[15:8]);
    repeat (HEADER_BYTES_DEF - 2) put(8'($urandom_range(0, 255)));
    repeat (PLANE_COUNT_DEF) begin
      fill = 0;
      while (fill < span) begin
        lim = span - fill;
        if (lim > 127) lim = 127;
        if (wild && $urandom_range(0, 7) == 0) lim = 127;
        n = $urandom_range(1, lim);
        case ($urandom_range(0, 9))
          0: begin
            put(8'h00);
            n = 0;
          end
          1: begin
            put({1'b1, 7'd0});
            put(8'($urandom_range(0, 255)));
            n = 0;
          end
          2, 3, 4: begin
            if (n > lit_max) n = $urandom_range(1, lit_max);
            put({1'b0, n[6:0]});
            repeat (n) put(8'($urandom_range(0, 255)));
          end
          default: begin
            put({1'b1, n[6:0]});
            put(8'($urandom_range(0, 255)));
          end
        endcase
        fill += n;
      end
    end
    if (kind < 6 && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) put(8'($urandom_range(0, 255)));
    if (kind == 7 || kind == 8) begin
      cut = $urandom_range(first, stream_q.size() - 1);
      while (stream_q.size() > cut + 1) void'(stream_q.pop_back());
    end
    stream_q[stream_q.size() - 1].last = 1'b1;
  endfunction

  task automatic send_word(logic [BYTE_W-1:0] b, bit last);
    int gap;
    gap = in_idle ? $urandom_range(0, 18) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_all();
    stream_word_t w;
    while (stream_q.size() != 0) begin
      w = stream_q.pop_front();
      send_word(w.data, w.last);
      if ($urandom_range(0, 59) == 0) in_idle = !in_idle;
    end
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (sb.due_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_strict(bit v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    sb.strict_end = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin : receiver
    int hold;
    forever begin
      hold = out_idle ? $urandom_range(0, 18) : 0;
      if (long_hold_req) begin
        hold = 300;
        long_hold_req = 1'b0;
      end
      if ($urandom_range(0, 59) == 0) out_idle = !out_idle;
      @(negedge clk);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : run
    int ph;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (DIRECTED[i]) put(DIRECTED[i][7:0], DIRECTED[i][8]);
    for (ph = 0; ph < 4; ph++) begin
      if (ph > 0) write_strict(ph == 2);
      if (ph == 2) long_hold_req = 1'b1;
      while (stream_q.size() < 430) add_image();
      send_all();
      wait_idle();
    end
    if (sb.fails == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin : limit
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end
endmodule
